[rtl/pid_controller_dual_form_unit_assert.svh]
// Assertion macros for the PID controller checker
`ifndef PID_CONTROLLER_DUAL_FORM_UNIT_ASSERT_SVH
`define PID_CONTROLLER_DUAL_FORM_UNIT_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define PIDDF_ASSERT_IMP(lbl, ant, con) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ant) |-> (con)) \
        else $error("piddf assertion failed");

// next-cycle implication, disabled while reset is asserted
`define PIDDF_ASSERT_NXT(lbl, ant, con) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ant) |=> (con)) \
        else $error("piddf assertion failed");

`endif

[rtl/piddf_pkg.sv]
// Shared widths, register indexes and pipeline word types of the PID controller
package piddf_pkg;

    localparam int ERR_W     = 16;
    localparam int GAIN_W    = 16;
    localparam int VAL_W     = 32;
    localparam int OPA_W     = 17;
    localparam int OPB_W     = 18;
    localparam int PA_W      = OPA_W + GAIN_W;
    localparam int PB_W      = OPB_W + GAIN_W;
    localparam int PC_W      = VAL_W + GAIN_W;
    localparam int SUM_W     = 50;
    localparam int CFG_IDX_W = 4;
    localparam int CFG_DAT_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODE     = 4'd0,
        CFG_GAIN_P   = 4'd1,
        CFG_GAIN_I   = 4'd2,
        CFG_GAIN_D   = 4'd3,
        CFG_OUT_HI   = 4'd4,
        CFG_OUT_LO   = 4'd5,
        CFG_INTEG_HI = 4'd6,
        CFG_INTEG_LO = 4'd7
    } t_cfg_idx;

    typedef struct packed {
        logic                    mode;
        logic signed [OPA_W-1:0] op_a;
        logic signed [OPB_W-1:0] op_b;
        logic signed [VAL_W-1:0] op_c;
    } t_op;

    typedef struct packed {
        logic                    mode;
        logic signed [SUM_W-1:0] sum;
    } t_sum;

endpackage

[rtl/piddf_mac.sv]
// Product and sum stages of the PID controller: three gain multiplies, then a wide sum
module piddf_mac (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_op_valid,
    input  piddf_pkg::t_op                          i_op,
    output logic                                    o_op_ready,
    input  logic signed [piddf_pkg::GAIN_W-1:0]     i_gain_p,
    input  logic signed [piddf_pkg::GAIN_W-1:0]     i_gain_i,
    input  logic signed [piddf_pkg::GAIN_W-1:0]     i_gain_d,
    output logic                                    o_sum_valid,
    output piddf_pkg::t_sum                         o_sum,
    input  logic                                    i_sum_ready
);
    import piddf_pkg::*;

    logic                   r_b_valid;
    logic                   r_b_mode;
    logic signed [PA_W-1:0] r_pa;
    logic signed [PB_W-1:0] r_pb;
    logic signed [PC_W-1:0] r_pc;
    logic signed [PA_W-1:0] n_pa;
    logic signed [PB_W-1:0] n_pb;
    logic signed [PC_W-1:0] n_pc;
    logic                   r_c_valid;
    t_sum                   r_sum;
    t_sum                   n_sum;
    logic                   en_b;
    logic                   en_c;

    assign en_c       = !r_c_valid || i_sum_ready;
    assign en_b       = !r_b_valid || en_c;
    assign o_op_ready = en_b;

    assign n_pa = PA_W'(i_op.op_a) * PA_W'(i_gain_p);
    assign n_pb = PB_W'(i_op.op_b) * PB_W'(i_gain_d);
    assign n_pc = PC_W'(i_op.op_c) * PC_W'(i_gain_i);

    assign n_sum.mode = r_b_mode;
    assign n_sum.sum  = SUM_W'(r_pa) + SUM_W'(r_pb) + SUM_W'(r_pc);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else begin
            if (en_b) begin
                r_b_valid <= i_op_valid;
            end
            if (en_c) begin
                r_c_valid <= r_b_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_b && i_op_valid) begin
            r_b_mode <= i_op.mode;
            r_pa     <= n_pa;
            r_pb     <= n_pb;
            r_pc     <= n_pc;
        end
        if (en_c && r_b_valid) begin
            r_sum <= n_sum;
        end
    end

    assign o_sum_valid = r_c_valid;
    assign o_sum       = r_sum;

endmodule

[rtl/pid_controller_dual_form_unit.sv]
// PID controller, positional or incremental form, fixed point, top level
// Path: an accepted error word passes the stage A, B, C and D registers to its drive word.
// Throughput: one word per cycle while the output does not stall; error state
// updates at accept, the drive feedback add and output clamp close in the last stage.
// Reset: synchronous, clears the pipeline, error state and drive history,
// and loads the register defaults (zero gains, full-range limits).
module pid_controller_dual_form_unit (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_cfg_valid,
    output logic                                      o_cfg_ready,
    input  logic [piddf_pkg::CFG_IDX_W-1:0]           i_cfg_index,
    input  logic [piddf_pkg::CFG_DAT_W-1:0]           i_cfg_data,
    input  logic                                      i_err_valid,
    output logic                                      o_err_stall,
    input  logic signed [piddf_pkg::ERR_W-1:0]        i_err_sample,
    output logic                                      o_drive_valid,
    input  logic                                      i_drive_stall,
    output logic signed [piddf_pkg::VAL_W-1:0]        o_drive_value
);
    import piddf_pkg::*;

    // configuration
    logic                     r_mode;
    logic signed [GAIN_W-1:0] r_gain_p;
    logic signed [GAIN_W-1:0] r_gain_i;
    logic signed [GAIN_W-1:0] r_gain_d;
    logic signed [VAL_W-1:0]  r_out_hi;
    logic signed [VAL_W-1:0]  r_out_lo;
    logic signed [VAL_W-1:0]  r_integ_hi;
    logic signed [VAL_W-1:0]  r_integ_lo;

    // controller state
    logic signed [ERR_W-1:0]  r_prev1;
    logic signed [ERR_W-1:0]  r_prev2;
    logic signed [VAL_W-1:0]  r_integral;
    logic signed [VAL_W-1:0]  r_drive_prev;

    logic                     r_a_valid;
    t_op                      r_a_op;
    t_op                      n_a_op;
    logic                     en_a;
    logic                     en_d;
    logic                     mac_ready;
    logic                     acc_in;

    logic signed [VAL_W:0]    integ_sum;
    logic signed [VAL_W:0]    integ_top;
    logic signed [VAL_W-1:0]  n_integral;
    logic signed [OPA_W-1:0]  d1;
    logic signed [OPB_W-1:0]  d2;

    logic                     sum_valid;
    t_sum                     sum_w;
    logic signed [SUM_W-1:0]  acc;
    logic signed [SUM_W-1:0]  acc_top;
    logic signed [VAL_W-1:0]  n_drive;
    logic                     r_drive_valid;
    logic signed [VAL_W-1:0]  r_drive;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= 1'b0;
            r_gain_p   <= '0;
            r_gain_i   <= '0;
            r_gain_d   <= '0;
            r_out_hi   <= {1'b0, {(VAL_W-1){1'b1}}};
            r_out_lo   <= {1'b1, {(VAL_W-1){1'b0}}};
            r_integ_hi <= {1'b0, {(VAL_W-1){1'b1}}};
            r_integ_lo <= {1'b1, {(VAL_W-1){1'b0}}};
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_MODE:     r_mode     <= i_cfg_data[0];
                CFG_GAIN_P:   r_gain_p   <= i_cfg_data[GAIN_W-1:0];
                CFG_GAIN_I:   r_gain_i   <= i_cfg_data[GAIN_W-1:0];
                CFG_GAIN_D:   r_gain_d   <= i_cfg_data[GAIN_W-1:0];
                CFG_OUT_HI:   r_out_hi   <= i_cfg_data[VAL_W-1:0];
                CFG_OUT_LO:   r_out_lo   <= i_cfg_data[VAL_W-1:0];
                CFG_INTEG_HI: r_integ_hi <= i_cfg_data[VAL_W-1:0];
                CFG_INTEG_LO: r_integ_lo <= i_cfg_data[VAL_W-1:0];
                default: ;
            endcase
        end
    end

    // handshake chain, stage D is the output register
    assign en_d        = !r_drive_valid || !i_drive_stall;
    assign en_a        = !r_a_valid || mac_ready;
    assign o_err_stall = !en_a;
    assign acc_in      = i_err_valid && en_a;

    // stage A: integral clamp and error differences; upper clamp then lower
    assign integ_sum  = (VAL_W+1)'(r_integral) + (VAL_W+1)'(i_err_sample);
    assign integ_top  = (integ_sum > (VAL_W+1)'(r_integ_hi)) ? (VAL_W+1)'(r_integ_hi)
                                                               : integ_sum;
    assign n_integral = (integ_top < (VAL_W+1)'(r_integ_lo)) ? r_integ_lo
                                                               : integ_top[VAL_W-1:0];
    assign d1 = OPA_W'(i_err_sample) - OPA_W'(r_prev1);
    assign d2 = OPB_W'(i_err_sample) - (OPB_W'(r_prev1) <<< 1) + OPB_W'(r_prev2);

    always_comb begin
        n_a_op.mode = r_mode;
        if (r_mode) begin
            n_a_op.op_a = d1;
            n_a_op.op_b = d2;
            n_a_op.op_c = VAL_W'(i_err_sample);
        end else begin
            n_a_op.op_a = OPA_W'(i_err_sample);
            n_a_op.op_b = OPB_W'(d1);
            n_a_op.op_c = n_integral;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid  <= 1'b0;
            r_prev1    <= '0;
            r_prev2    <= '0;
            r_integral <= '0;
        end else begin
            if (en_a) begin
                r_a_valid <= i_err_valid;
            end
            if (acc_in) begin
                r_prev1 <= i_err_sample;
                if (r_mode) begin
                    r_prev2 <= r_prev1;
                end else begin
                    r_integral <= n_integral;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc_in) begin
            r_a_op <= n_a_op;
        end
    end

    piddf_mac u_mac (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op_valid  (r_a_valid),
        .i_op        (r_a_op),
        .o_op_ready  (mac_ready),
        .i_gain_p    (r_gain_p),
        .i_gain_i    (r_gain_i),
        .i_gain_d    (r_gain_d),
        .o_sum_valid (sum_valid),
        .o_sum       (sum_w),
        .i_sum_ready (en_d)
    );

    // stage D: drive feedback and output clamp
    assign acc     = sum_w.sum + (sum_w.mode ? SUM_W'(r_drive_prev) : SUM_W'(0));
    assign acc_top = (acc > SUM_W'(r_out_hi)) ? SUM_W'(r_out_hi) : acc;
    assign n_drive = (acc_top < SUM_W'(r_out_lo)) ? r_out_lo : acc_top[VAL_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drive_valid <= 1'b0;
            r_drive_prev  <= '0;
        end else if (en_d) begin
            r_drive_valid <= sum_valid;
            if (sum_valid && sum_w.mode) begin
                r_drive_prev <= n_drive;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_d && sum_valid) begin
            r_drive <= n_drive;
        end
    end

    assign o_drive_valid = r_drive_valid;
    assign o_drive_value = r_drive;

endmodule

[rtl/piddf_chk.sv]
// Port-level checker for the PID controller, bound to the top level
`include "pid_controller_dual_form_unit_assert.svh"

module piddf_chk (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_err_valid,
    input  logic                                  o_err_stall,
    input  logic                                  o_drive_valid,
    input  logic                                  i_drive_stall,
    input  logic signed [piddf_pkg::VAL_W-1:0]    o_drive_value
);

    // a free output side never backs up the input
    `PIDDF_ASSERT_IMP(a_no_stall_when_free, !i_drive_stall, !o_err_stall)

    // an empty output register frees the whole chain, so an offered word is taken
    `PIDDF_ASSERT_IMP(a_empty_out_accepts, i_err_valid && !o_drive_valid, !o_err_stall)

    `PIDDF_ASSERT_NXT(a_drive_held, o_drive_valid && i_drive_stall, o_drive_valid)

    `PIDDF_ASSERT_NXT(a_drive_stable, o_drive_valid && i_drive_stall, $stable(o_drive_value))

endmodule

bind pid_controller_dual_form_unit piddf_chk u_piddf_chk (.*);
